### src/asp_pkg.sv
// Package for the alarm sounder: alert and request codes, tone values, pattern timing
// thresholds, configuration defaults and the structs passed between modules.
// No dependencies.
package asp_pkg;

    // Request kinds carried by an input item.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Alert codes; codes six and seven mean nothing.
    localparam logic [2:0] ALERT_OFF    = 3'd0;
    localparam logic [2:0] ALERT_TEMP   = 3'd1;
    localparam logic [2:0] ALERT_LIGHT  = 3'd2;
    localparam logic [2:0] ALERT_PERSON = 3'd3;
    localparam logic [2:0] ALERT_FALL   = 3'd4;
    localparam logic [2:0] ALERT_FLAME  = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_MUTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT_MAX    = 1'd1;

    localparam int unsigned CFG_DATA_W       = 16;
    localparam logic [15:0] STARTUP_MUTE_DEF = 16'd5000;
    localparam logic [15:0] ALERT_MAX_DEF    = 16'd3000;

    localparam int unsigned TIME_WIDTH_DEF = 16;

    // Tones in Hz.
    localparam int unsigned TONE_W = 12;
    localparam logic [11:0] TONE_SILENT     = 12'd1000;
    localparam logic [11:0] TONE_IDLE       = 12'd2000;
    localparam logic [11:0] TONE_TEMP       = 12'd1200;
    localparam logic [11:0] TONE_LIGHT      = 12'd2100;
    localparam logic [11:0] TONE_PERSON     = 12'd2600;
    localparam logic [11:0] TONE_FALL_LOW   = 12'd700;
    localparam logic [11:0] TONE_FALL_HIGH  = 12'd1400;
    localparam logic [11:0] TONE_FLAME_HIGH = 12'd3300;
    localparam logic [11:0] TONE_FLAME_LOW  = 12'd2800;

    // Pattern timing in milliseconds of phase.
    localparam logic [31:0] TEMP_ON1_END   = 32'd120;
    localparam logic [31:0] TEMP_ON2_START = 32'd260;
    localparam logic [31:0] TEMP_ON2_END   = 32'd380;
    localparam logic [31:0] TEMP_PERIOD    = 32'd1600;
    localparam logic [31:0] LIGHT_PERIOD   = 32'd160;
    localparam logic [31:0] LIGHT_ON_END   = 32'd80;
    localparam logic [31:0] PERSON_ON_END  = 32'd120;
    localparam logic [31:0] FALL_PERIOD    = 32'd500;
    localparam logic [31:0] FALL_TONE_EDGE = 32'd250;
    localparam logic [31:0] FLAME_PERIOD   = 32'd180;
    localparam logic [31:0] FLAME_TONE_END = 32'd90;
    localparam logic [31:0] FLAME_ON_END   = 32'd130;

    typedef struct packed {
        logic [15:0] startup_mute;
        logic [15:0] alert_max;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] alert;
    } t_step;

    typedef struct packed {
        logic        on;
        logic [11:0] tone;
        logic        restart;
        logic        ends;
    } t_pattern;

    // Set priority: fall above flame above temp/humidity and light above person.
    function automatic logic [2:0] prio_of(input logic [2:0] a);
        logic [2:0] p;
        case (a)
            ALERT_FALL:              p = 3'd5;
            ALERT_FLAME:             p = 3'd4;
            ALERT_TEMP, ALERT_LIGHT: p = 3'd3;
            ALERT_PERSON:            p = 3'd1;
            default:                 p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

### src/asp_if.sv
// Handshake channels of the alarm sounder: request items, result items, register writes.
// Depends on asp_pkg.
interface asp_item_if
    import asp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] alert;

    modport source (output valid, output kind, output alert, input ready);
    modport sink   (input valid, input kind, input alert, output ready);
endinterface

interface asp_result_if
    import asp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              sound_on;
    logic [TONE_W-1:0] tone_hz;
    logic [2:0]        active_alert;

    modport source (output valid, output sound_on, output tone_hz, output active_alert,
                    input ready);
    modport sink   (input valid, input sound_on, input tone_hz, input active_alert,
                    output ready);
endinterface

interface asp_cfg_if
    import asp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/asp_pattern.sv
// Rhythm and tone table of each alert kind, evaluated on the advanced phase.
// Depends on asp_pkg.
module asp_pattern
    import asp_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic [2:0]            i_alert,
    input  logic [TIME_WIDTH-1:0] i_phase,
    output t_pattern              o_pat
);

    logic [31:0] d;

    assign d = 32'(i_phase);

    always_comb begin
        o_pat = '{on: 1'b0, tone: TONE_IDLE, restart: 1'b0, ends: 1'b0};
        case (i_alert)
            ALERT_TEMP: begin
                o_pat.tone    = TONE_TEMP;
                o_pat.on      = (d < TEMP_ON1_END) || (d >= TEMP_ON2_START && d < TEMP_ON2_END);
                o_pat.restart = (d >= TEMP_PERIOD);
            end
            ALERT_LIGHT: begin
                // A wrapped phase counts as zero, which is inside the on window.
                o_pat.tone    = TONE_LIGHT;
                o_pat.restart = (d >= LIGHT_PERIOD);
                o_pat.on      = (d >= LIGHT_PERIOD) || (d < LIGHT_ON_END);
            end
            ALERT_PERSON: begin
                o_pat.tone = TONE_PERSON;
                o_pat.on   = (d < PERSON_ON_END);
                o_pat.ends = !(d < PERSON_ON_END);
            end
            ALERT_FALL: begin
                o_pat.restart = (d >= FALL_PERIOD);
                o_pat.on      = 1'b1;
                o_pat.tone    = (d >= FALL_PERIOD || d < FALL_TONE_EDGE) ?
                                TONE_FALL_LOW : TONE_FALL_HIGH;
            end
            ALERT_FLAME: begin
                o_pat.restart = (d >= FLAME_PERIOD);
                o_pat.tone    = (d >= FLAME_PERIOD || d < FLAME_TONE_END) ?
                                TONE_FLAME_HIGH : TONE_FLAME_LOW;
                o_pat.on      = (d >= FLAME_PERIOD) || (d < FLAME_ON_END);
            end
            default: ;
        endcase
    end

endmodule

### src/asp_core.sv
// Alert state, time counters and the sounder drive, updated once per taken item.
// Depends on asp_pkg and asp_pattern.
module asp_core
    import asp_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_take,
    input  t_step             i_step,
    output logic              o_sound_on,
    output logic [TONE_W-1:0] o_tone_hz,
    output logic [2:0]        o_active_alert
);

    logic [2:0]            r_alert, n_alert;
    logic [TIME_WIDTH-1:0] r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_age, n_age;
    logic                  r_armed, n_armed;
    logic [TIME_WIDTH-1:0] r_boot, n_boot;
    logic                  r_drive, n_drive;
    logic [TONE_W-1:0]     r_tone, n_tone;

    logic [TIME_WIDTH-1:0] phase_inc, age_inc, boot_inc;
    logic                  set_ok;
    t_pattern              pat;

    assign phase_inc = (&r_phase) ? r_phase : r_phase + TIME_WIDTH'(1);
    assign age_inc   = (&r_age)   ? r_age   : r_age + TIME_WIDTH'(1);
    assign boot_inc  = (&r_boot)  ? r_boot  : r_boot + TIME_WIDTH'(1);

    asp_pattern #(.TIME_WIDTH(TIME_WIDTH)) u_pattern (
        .i_alert (r_alert),
        .i_phase (phase_inc),
        .o_pat   (pat)
    );

    // Fall blocks every set, flame yields only to fall, otherwise priority decides.
    assign set_ok = (r_alert != ALERT_FALL)
                 && !(r_alert == ALERT_FLAME && i_step.alert != ALERT_FALL)
                 && (prio_of(i_step.alert) >= prio_of(r_alert));

    always_comb begin
        n_alert = r_alert;
        n_phase = r_phase;
        n_age   = r_age;
        n_armed = r_armed;
        n_boot  = r_boot;
        n_drive = r_drive;
        n_tone  = r_tone;
        if (i_take) begin
            case (i_step.kind)
                KIND_TICK: begin
                    n_boot  = boot_inc;
                    n_phase = phase_inc;
                    n_age   = age_inc;
                    if (32'(boot_inc) < 32'(i_cfg.startup_mute)) begin
                        n_drive = 1'b0;
                        n_tone  = TONE_SILENT;
                    end else if (r_alert != ALERT_OFF && r_armed
                                 && 32'(age_inc) >= 32'(i_cfg.alert_max)) begin
                        n_alert = ALERT_OFF;
                        n_drive = 1'b0;
                        n_tone  = TONE_SILENT;
                    end else begin
                        n_drive = pat.on;
                        n_tone  = pat.tone;
                        if (pat.restart) begin
                            n_phase = '0;
                        end
                        if (pat.ends) begin
                            n_alert = ALERT_OFF;
                        end
                    end
                end
                KIND_SET: begin
                    if (i_step.alert == ALERT_OFF) begin
                        n_alert = ALERT_OFF;
                        n_armed = 1'b0;
                        n_drive = 1'b0;
                        n_tone  = TONE_SILENT;
                    end else if (i_step.alert <= ALERT_FLAME && set_ok) begin
                        if (r_alert != i_step.alert) begin
                            n_age   = '0;
                            n_armed = 1'b1;
                        end
                        n_alert = i_step.alert;
                        n_phase = '0;
                        n_drive = 1'b0;
                        n_tone  = TONE_SILENT;
                    end
                end
                KIND_CLEAR: begin
                    if (i_step.alert == r_alert) begin
                        n_alert = ALERT_OFF;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert <= ALERT_OFF;
            r_phase <= '0;
            r_age   <= '0;
            r_armed <= 1'b0;
            r_boot  <= '0;
            r_drive <= 1'b0;
            r_tone  <= TONE_SILENT;
        end else begin
            r_alert <= n_alert;
            r_phase <= n_phase;
            r_age   <= n_age;
            r_armed <= n_armed;
            r_boot  <= n_boot;
            r_drive <= n_drive;
            r_tone  <= n_tone;
        end
    end

    assign o_sound_on     = r_drive;
    assign o_tone_hz      = r_tone;
    assign o_active_alert = r_alert;

endmodule

### src/alarm_sounder_priority_pattern.sv
// Top level of the alarm sounder controller: input register, configuration registers
// and the result handshake. Depends on asp_pkg, asp_if and asp_core.
//
// Usage. Items arrive on i_item: a 1 ms tick, a set request or a clear request, each
// naming an alert code. Every accepted item yields exactly one result item on o_result,
// which reports the sounder drive, the tone and the alert in force after that item.
// Two registers, the startup mute time and the maximum alert age, are written through
// i_cfg, which is always ready; write them only while no item is in flight.
//
// Timing. One combinational pass from the input register updates the state registers,
// which double as the result register: an item goes from the input register to them,
// and while o_result is ready the sustained rate is one item per cycle.
//
// Stalls. While a result waits on o_result, the state is frozen; the input register
// still takes one more item, so i_item.ready drops only when both stages are full.
// Nothing is lost or repeated across a stall.
//
// Reset. The synchronous active-low reset empties both stages, loads the register
// defaults (5000 ms mute, 3000 ms maximum age), clears the alert and the counters and
// sets the tone to 1000 Hz with the sounder off.
module alarm_sounder_priority_pattern
    import asp_pkg::*;
#(
    parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    asp_item_if.sink     i_item,
    asp_cfg_if.sink      i_cfg,
    asp_result_if.source o_result
);

    logic  r_in_valid;
    t_step r_in_step;
    logic  r_out_valid;
    t_cfg  r_cfg;
    logic  advance;

    // The held item moves into the state when the result slot is free or being emptied.
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg       <= '{startup_mute: STARTUP_MUTE_DEF, alert_max: ALERT_MAX_DEF};
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_STARTUP_MUTE: r_cfg.startup_mute <= i_cfg.data;
                    CFG_ALERT_MAX:    r_cfg.alert_max    <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Payload of the input stage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_step <= '{kind: i_item.kind, alert: i_item.alert};
        end
    end

    asp_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_take         (advance),
        .i_step         (r_in_step),
        .o_sound_on     (o_result.sound_on),
        .o_tone_hz      (o_result.tone_hz),
        .o_active_alert (o_result.active_alert)
    );

    assign o_result.valid = r_out_valid;

endmodule
